// ===== rtl/core/ccs_pkg.sv =====
// Shared types and constants for the palette channel scaler.
// Used by ccs_div_stage, ccs_lane and colormap_channel_scaler; depends on nothing.
`default_nettype none

package ccs_pkg;

	localparam int CHAN_W      = 16;
	localparam int WIDTH_W     = 5;
	localparam int MAX_WIDTH   = 16;
	localparam int NUM_LANES   = 4;
	localparam int DIV_STEPS   = 16;
	localparam int LANE_STAGES = DIV_STEPS + 1;
	localparam int CFG_IDX_W   = 2;

	localparam logic [31:0]   ROUND_HALF  = 32'h0000_7fff;
	localparam logic [16:0]   DEN_SHIFT16 = 17'h1_0000;
	localparam logic [31:0]   SAT_NUMER   = 32'hffff_0000;
	localparam logic [WIDTH_W-1:0] RESET_WIDTH_RGB = 5'd8;
	localparam logic [WIDTH_W-1:0] RESET_WIDTH_A   = 5'd0;

	typedef enum logic {
		OP_TO_HW   = 1'b0,
		OP_FROM_HW = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_WIDTH   = 2'd0,
		REG_GREEN_WIDTH = 2'd1,
		REG_BLUE_WIDTH  = 2'd2,
		REG_ALPHA_WIDTH = 2'd3
	} reg_idx_t;

	// Working set of one restoring-division step. The quotient bits shift in
	// at the bottom of lq while the dividend bits leave at the top.
	typedef struct packed {
		logic [16:0]       den;
		logic [CHAN_W-1:0] rem;
		logic [CHAN_W-1:0] lq;
	} div_t;

endpackage

`default_nettype wire

// ===== rtl/core/colormap_channel_scaler.sv =====
// Pipeline: an accepted item loads the setup register, then moves through 16 division stages
// and the output register to show its result on out_valid; a stall on the output side holds it.
// Throughput: one item per cycle while the output side does not stall; each lane's divider
// retires one quotient bit per stage.
// Reset (arst_n low, asynchronous): the pipeline and output are emptied, the widths become
// red 8, green 8, blue 8, transparency 0.
`default_nettype none

module colormap_channel_scaler
	import ccs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WIDTH_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire logic [CHAN_W-1:0]    chan_red,
	input  wire logic [CHAN_W-1:0]    chan_green,
	input  wire logic [CHAN_W-1:0]    chan_blue,
	input  wire logic [CHAN_W-1:0]    chan_alpha,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [CHAN_W-1:0]    out_red,
	output logic      [CHAN_W-1:0]    out_green,
	output logic      [CHAN_W-1:0]    out_blue,
	output logic      [CHAN_W-1:0]    out_alpha
);

	// Width registers, one per channel, written through the plain write port.
	logic [WIDTH_W-1:0] red_width_q;
	logic [WIDTH_W-1:0] green_width_q;
	logic [WIDTH_W-1:0] blue_width_q;
	logic [WIDTH_W-1:0] alpha_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_width_q   <= RESET_WIDTH_RGB;
			green_width_q <= RESET_WIDTH_RGB;
			blue_width_q  <= RESET_WIDTH_RGB;
			alpha_width_q <= RESET_WIDTH_A;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RED_WIDTH:   red_width_q   <= cfg_data;
				REG_GREEN_WIDTH: green_width_q <= cfg_data;
				REG_BLUE_WIDTH:  blue_width_q  <= cfg_data;
				REG_ALPHA_WIDTH: alpha_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control. Every lane runs the same stages in lockstep, so one
	// set of valid bits serves all four. A stage may load when it is empty
	// or when the stage after it moves on, so bubbles are squeezed out and
	// new items keep entering while a finished result waits at the output.
	logic [LANE_STAGES-1:0] stage_v_q;
	logic [LANE_STAGES:0]   free;
	logic                   out_valid_q;

	always_comb begin
		free[LANE_STAGES] = !out_valid_q || !out_stall;
		for (int k = LANE_STAGES - 1; k >= 0; k--) begin
			free[k] = !stage_v_q[k] || free[k+1];
		end
	end

	assign in_stall = !free[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (free[0]) begin
				stage_v_q[0] <= in_valid;
			end
			for (int k = 1; k < LANE_STAGES; k++) begin
				if (free[k]) begin
					stage_v_q[k] <= stage_v_q[k-1];
				end
			end
			if (free[LANE_STAGES]) begin
				out_valid_q <= stage_v_q[LANE_STAGES-1];
			end
		end
	end

	// Four identical lanes, one for each channel of the palette entry.
	logic [CHAN_W-1:0]  lane_chan  [NUM_LANES];
	logic [WIDTH_W-1:0] lane_width [NUM_LANES];
	logic [CHAN_W-1:0]  lane_res   [NUM_LANES];

	assign lane_chan[0]  = chan_red;
	assign lane_chan[1]  = chan_green;
	assign lane_chan[2]  = chan_blue;
	assign lane_chan[3]  = chan_alpha;
	assign lane_width[0] = red_width_q;
	assign lane_width[1] = green_width_q;
	assign lane_width[2] = blue_width_q;
	assign lane_width[3] = alpha_width_q;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ccs_lane u_lane (
			.clk    (clk),
			.en     (free[LANE_STAGES-1:0]),
			.opcode (opcode),
			.chan   (lane_chan[g]),
			.width  (lane_width[g]),
			.res    (lane_res[g])
		);
	end

	// Merge stage: the four lane results are gathered into one output item.
	logic [CHAN_W-1:0] out_red_q;
	logic [CHAN_W-1:0] out_green_q;
	logic [CHAN_W-1:0] out_blue_q;
	logic [CHAN_W-1:0] out_alpha_q;

	always_ff @(posedge clk) begin
		if (free[LANE_STAGES] && stage_v_q[LANE_STAGES-1]) begin
			out_red_q   <= lane_res[0];
			out_green_q <= lane_res[1];
			out_blue_q  <= lane_res[2];
			out_alpha_q <= lane_res[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_alpha = out_alpha_q;

`ifndef SYNTHESIS
	// With the output register empty nothing can hold the pipeline back.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled while the output register is empty");

	// The input only stalls when every stage holds an item and the output is blocked.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&stage_v_q && out_valid_q && out_stall))
		else $error("input stalled with room left in the pipeline");

	// A result leaves the output register only by being taken.
	a_result_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> !$past(out_stall))
		else $error("result item dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ccs_div_stage.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on ccs_pkg for div_t.
`default_nettype none

module ccs_div_stage
	import ccs_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire div_t d_in,
	output div_t      d_out
);

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;
	div_t        nxt;
	div_t        step_q;

	always_comb begin
		trial   = {d_in.rem, d_in.lq[CHAN_W-1]};
		ge      = (trial >= d_in.den);
		diff    = ge ? (trial - d_in.den) : trial;
		// The partial remainder stays below the divisor, so it fits in 16 bits.
		nxt.den = d_in.den;
		nxt.rem = diff[CHAN_W-1:0];
		nxt.lq  = {d_in.lq[CHAN_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_q <= nxt;
		end
	end

	assign d_out = step_q;

endmodule

`default_nettype wire

// ===== rtl/core/ccs_lane.sv =====
// One channel lane: operand setup followed by a 16-stage division pipeline.
// Depends on ccs_pkg and ccs_div_stage.
`default_nettype none

module ccs_lane
	import ccs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic [LANE_STAGES-1:0] en,
	input  wire logic                   opcode,
	input  wire logic [CHAN_W-1:0]      chan,
	input  wire logic [WIDTH_W-1:0]     width,
	output logic      [CHAN_W-1:0]      res
);

	logic [WIDTH_W-1:0] cw;
	logic [16:0]        mask;
	logic [CHAN_W-1:0]  top;
	logic [31:0]        numer;
	logic [16:0]        den;
	div_t               prep;
	div_t               prep_s1;
	div_t               chain [DIV_STEPS+1];

	// Both directions end as a numerator over a divisor. Going to hardware
	// the divisor is 2^16, so the quotient is the rounded rescale; the
	// special cases of the return path are folded into the operands.
	always_comb begin
		cw   = (width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width;
		mask = (17'd1 << cw) - 17'd1;
		top  = mask[CHAN_W-1:0];
		if (op_t'(opcode) == OP_TO_HW) begin
			numer = (32'(chan) << cw) - 32'(chan) + ROUND_HALF;
			den   = DEN_SHIFT16;
		end else if (cw == '0) begin
			numer = '0;
			den   = 17'd1;
		end else if (chan > top) begin
			numer = SAT_NUMER;
			den   = DEN_SHIFT16;
		end else begin
			numer = {chan, 16'h0000} - 32'(chan);
			den   = {1'b0, top};
		end
		prep.den = den;
		prep.rem = numer[31:16];
		prep.lq  = numer[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prep_s1 <= prep;
		end
	end

	assign chain[0] = prep_s1;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		ccs_div_stage u_step (
			.clk   (clk),
			.en    (en[g+1]),
			.d_in  (chain[g]),
			.d_out (chain[g+1])
		);
	end

	assign res = chain[DIV_STEPS].lq;

endmodule

`default_nettype wire
